@@ sv/kmrl_pkg.sv @@
// shared types and constants of the k-mismatch read locator
`default_nettype none

package kmrl_pkg;

  localparam int READ_MAX_DEF = 128;
  localparam int POS_BITS_DEF = 24;

  localparam int SYM_W     = 8;
  localparam int CFG_W     = 8;
  localparam int RPOS_W    = 7;
  localparam int OUT_POS_W = 24;
  localparam int CNT_W     = 8;
  localparam int S_DATA_W  = 16;
  localparam int M_DATA_W  = 32;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] READ_LENGTH_RST  = 8'd128;
  localparam logic [CFG_W-1:0] MAX_MISMATCH_RST = 8'd4;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_REF    = 2'd1,
    REQ_FINISH = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_READ_LENGTH  = 1'b0,
    REG_MAX_MISMATCH = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN,
    ST_DECIDE
  } state_e;

  typedef struct packed {
    logic shift;
    logic rotate;
    logic clear;
  } chain_ctrl_t;

endpackage

`default_nettype wire

@@ sv/kmrl_cell.sv @@
// one window cell: holds a reference symbol and passes it to its neighbour
`default_nettype none

module kmrl_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  kmrl_pkg::chain_ctrl_t     ctrl_i,
  input  logic [kmrl_pkg::SYM_W-1:0] sym_i,
  output logic [kmrl_pkg::SYM_W-1:0] sym_o
);

  logic [kmrl_pkg::SYM_W-1:0] sym_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= '0;
    end else if (ctrl_i.clear) begin
      sym_q <= '0;
    end else if (ctrl_i.shift || ctrl_i.rotate) begin
      sym_q <= sym_i;
    end
  end

  assign sym_o = sym_q;

endmodule

`default_nettype wire

@@ sv/kmrl_chain.sv @@
// row of window cells, newest symbol in cell 0, tail fed back when rotating
`default_nettype none

module kmrl_chain #(
  parameter int READ_MAX = kmrl_pkg::READ_MAX_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kmrl_pkg::chain_ctrl_t      ctrl_i,
  input  logic [kmrl_pkg::SYM_W-1:0] sym_i,
  output logic [kmrl_pkg::SYM_W-1:0] tail_o
);

  logic [kmrl_pkg::SYM_W-1:0] link [READ_MAX+1];

  assign link[0] = ctrl_i.rotate ? link[READ_MAX] : sym_i;

  for (genvar k = 0; k < READ_MAX; k++) begin : g_cell
    kmrl_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .sym_i  (link[k]),
      .sym_o  (link[k+1])
    );
  end

  assign tail_o = link[READ_MAX];

endmodule

`default_nettype wire

@@ sv/k_mismatch_read_locator.sv @@
// top level of the k-mismatch read locator
// a load, finish or non-evaluating reference transfer keeps the block in the idle state
// an evaluating reference transfer enters the evaluate state: the window ring turns once
// through all READ_MAX cells while one read symbol a cycle is compared, then drain and decide
// a finish result sits in the output register the cycle after its transfer
// asynchronous active-low reset clears window, counters, best match and output valid
`default_nettype none

module k_mismatch_read_locator #(
  parameter int READ_MAX = kmrl_pkg::READ_MAX_DEF,
  parameter int POS_BITS = kmrl_pkg::POS_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [kmrl_pkg::S_DATA_W-1:0]   s_axis_tdata,  // symbol, read_pos, zero pad
  input  logic [kmrl_pkg::REQ_W-1:0]      s_axis_tuser,  // req_type
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [kmrl_pkg::M_DATA_W-1:0]   m_axis_tdata,  // best_position, best_mismatches
  output logic                            m_axis_tuser,  // found
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kmrl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kmrl_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int IDX_W  = $clog2(READ_MAX);
  localparam int FILL_W = $clog2(READ_MAX + 1);
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [IDX_W-1:0]    STEP_LAST = IDX_W'(READ_MAX - 1);
  localparam logic [FILL_W-1:0]   FILL_FULL = FILL_W'(READ_MAX);

  kmrl_pkg::state_e state_q, state_d;
  kmrl_pkg::chain_ctrl_t ctrl;

  logic [kmrl_pkg::CFG_W-1:0] read_length_q, max_mismatch_q;
  logic [kmrl_pkg::CFG_W-1:0] eff_len;

  logic [kmrl_pkg::SYM_W-1:0]  in_sym;
  logic [kmrl_pkg::RPOS_W-1:0] in_rpos;
  logic                        s_xfer;
  logic                        is_load, is_ref, is_finish;

  logic [FILL_W-1:0]   fill_q, fill_inc;
  logic [POS_BITS-1:0] pos_q, best_start_q;
  logic [kmrl_pkg::CNT_W-1:0] best_cnt_q, miss_q;
  logic                hit_q;
  logic                counting, go_eval;

  logic [IDX_W-1:0]           step_q;
  logic                       step_act;
  logic [IDX_W-1:0]           rd_addr;
  logic [kmrl_pkg::SYM_W-1:0] tail;
  logic [kmrl_pkg::SYM_W-1:0] tap_q, rdata_q;
  logic                       act_q, pipe_q;
  logic                       better;

  logic [kmrl_pkg::SYM_W-1:0] rstore [READ_MAX];
  logic                       wr_en;

  logic                            m_valid_q, m_found_q;
  logic [kmrl_pkg::OUT_POS_W-1:0]  m_pos_q;
  logic [kmrl_pkg::CNT_W-1:0]      m_cnt_q;

  assign in_sym  = s_axis_tdata[kmrl_pkg::SYM_W-1:0];
  assign in_rpos = s_axis_tdata[kmrl_pkg::SYM_W +: kmrl_pkg::RPOS_W];

  always_comb begin
    is_load   = 1'b0;
    is_ref    = 1'b0;
    is_finish = 1'b0;
    unique case (s_axis_tuser)
      kmrl_pkg::REQ_LOAD:   is_load   = 1'b1;
      kmrl_pkg::REQ_REF:    is_ref    = 1'b1;
      kmrl_pkg::REQ_FINISH: is_finish = 1'b1;
      default: ;
    endcase
  end

  // effective read length
  always_comb begin
    priority if (read_length_q == '0) begin
      eff_len = kmrl_pkg::CFG_W'(1);
    end else if (16'(read_length_q) > 16'(READ_MAX)) begin
      eff_len = kmrl_pkg::CFG_W'(READ_MAX);
    end else begin
      eff_len = read_length_q;
    end
  end

  assign s_xfer   = s_axis_tvalid && s_axis_tready;
  assign counting = (pos_q != POS_MAX);
  assign fill_inc = (fill_q == FILL_FULL) ? fill_q : fill_q + FILL_W'(1);
  assign go_eval  = is_ref && counting && (16'(fill_inc) >= 16'(eff_len));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      kmrl_pkg::ST_IDLE: begin
        if (s_xfer && go_eval) state_d = kmrl_pkg::ST_EVAL;
      end
      kmrl_pkg::ST_EVAL: begin
        if (step_q == STEP_LAST) state_d = kmrl_pkg::ST_DRAIN;
      end
      kmrl_pkg::ST_DRAIN:  state_d = kmrl_pkg::ST_DECIDE;
      kmrl_pkg::ST_DECIDE: state_d = kmrl_pkg::ST_IDLE;
      default:             state_d = kmrl_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ctrl          = '0;
    unique case (state_q)
      kmrl_pkg::ST_IDLE: begin
        s_axis_tready = !m_valid_q || m_axis_tready;
        ctrl.shift    = s_xfer && is_ref;
        ctrl.clear    = s_xfer && is_finish;
      end
      kmrl_pkg::ST_EVAL: ctrl.rotate = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kmrl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_length_q  <= kmrl_pkg::READ_LENGTH_RST;
      max_mismatch_q <= kmrl_pkg::MAX_MISMATCH_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        kmrl_pkg::REG_READ_LENGTH:  read_length_q  <= cfg_data_i;
        kmrl_pkg::REG_MAX_MISMATCH: max_mismatch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  kmrl_chain #(
    .READ_MAX (READ_MAX)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .sym_i  (in_sym),
    .tail_o (tail)
  );

  // read store
  assign wr_en    = s_xfer && is_load && (16'(in_rpos) < 16'(READ_MAX));
  assign step_act = (16'(step_q) + 16'(eff_len)) >= 16'(READ_MAX);
  assign rd_addr  = IDX_W'(16'(step_q) + 16'(eff_len) - 16'(READ_MAX));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rstore[IDX_W'(in_rpos)] <= in_sym;
    end
    rdata_q <= rstore[rd_addr];
    tap_q   <= tail;
  end

  // scan state and mismatch accumulation
  assign better = (miss_q <= max_mismatch_q) && (!hit_q || (miss_q < best_cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      pos_q        <= '0;
      best_start_q <= '0;
      best_cnt_q   <= '0;
      hit_q        <= 1'b0;
      step_q       <= '0;
      miss_q       <= '0;
      act_q        <= 1'b0;
      pipe_q       <= 1'b0;
    end else begin
      pipe_q <= (state_q == kmrl_pkg::ST_EVAL);
      act_q  <= step_act;
      if (pipe_q && act_q && (rdata_q != tap_q)) begin
        miss_q <= miss_q + kmrl_pkg::CNT_W'(1);
      end
      if (state_q == kmrl_pkg::ST_EVAL) begin
        step_q <= step_q + IDX_W'(1);
      end
      if (state_q == kmrl_pkg::ST_DECIDE && better) begin
        hit_q        <= 1'b1;
        best_cnt_q   <= miss_q;
        best_start_q <= pos_q - POS_BITS'(eff_len);
      end
      if (s_xfer && is_ref) begin
        fill_q <= fill_inc;
        if (counting) pos_q <= pos_q + POS_BITS'(1);
        if (go_eval) begin
          step_q <= '0;
          miss_q <= '0;
        end
      end
      if (s_xfer && is_finish) begin
        fill_q       <= '0;
        pos_q        <= '0;
        best_start_q <= '0;
        best_cnt_q   <= '0;
        hit_q        <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_xfer && is_finish) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer && is_finish) begin
      m_found_q <= hit_q;
      m_pos_q   <= hit_q ? kmrl_pkg::OUT_POS_W'(best_start_q) : '0;
      m_cnt_q   <= hit_q ? best_cnt_q : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_found_q;
  assign m_axis_tdata  = {m_cnt_q, m_pos_q};

endmodule

`default_nettype wire

@@ sv/kmrl_checker.sv @@
// port-level checks of the k-mismatch read locator, bound to the top level
`default_nettype none

module kmrl_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [kmrl_pkg::REQ_W-1:0]      s_axis_tuser,  // req_type
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [kmrl_pkg::M_DATA_W-1:0]   m_axis_tdata,  // best_position, best_mismatches
  input logic                            m_axis_tuser   // found
);

  logic s_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_no_hit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("result without hit carries data");

  a_finish_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && s_axis_tuser == kmrl_pkg::REQ_FINISH |=> m_axis_tvalid)
    else $error("finish transfer gave no result");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_xfer && s_axis_tuser == kmrl_pkg::REQ_FINISH))
    else $error("result without finish transfer");

  a_load_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && s_axis_tuser == kmrl_pkg::REQ_LOAD && !m_axis_tvalid |=> s_axis_tready)
    else $error("read load stalled the input");

endmodule

bind k_mismatch_read_locator kmrl_checker u_kmrl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ dv/tb_k_mismatch_read_locator.sv @@
// self-checking testbench for the k-mismatch read locator
`timescale 1ns / 1ps

module tb_k_mismatch_read_locator;

  localparam int READ_MAX  = kmrl_pkg::READ_MAX_DEF;
  localparam int SYM_W     = kmrl_pkg::SYM_W;
  localparam int RPOS_W    = kmrl_pkg::RPOS_W;
  localparam int REQ_W     = kmrl_pkg::REQ_W;
  localparam int CFG_W     = kmrl_pkg::CFG_W;
  localparam int CFG_IDX_W = kmrl_pkg::CFG_IDX_W;
  localparam int OUT_POS_W = kmrl_pkg::OUT_POS_W;
  localparam int CNT_W     = kmrl_pkg::CNT_W;
  localparam int S_DATA_W  = kmrl_pkg::S_DATA_W;
  localparam int M_DATA_W  = kmrl_pkg::M_DATA_W;
  localparam longint POS_LIMIT = (64'd1 << kmrl_pkg::POS_BITS_DEF) - 1;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [REQ_W-1:0]  kind;
    logic [SYM_W-1:0]  sym;
    logic [RPOS_W-1:0] pos;
  } req_item_t;

  typedef struct {
    logic                 found;
    logic [OUT_POS_W-1:0] pos;
    logic [CNT_W-1:0]     cnt;
  } outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_DATA_W-1:0]  s_axis_tdata = '0;  // symbol, read_pos, zero pad
  logic [REQ_W-1:0]     s_axis_tuser = '0;  // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]  m_axis_tdata;       // best_position, best_mismatches
  logic                 m_axis_tuser;       // found
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  k_mismatch_read_locator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  req_item_t   pending_q[$];
  outcome_t    outcome_q[$];
  int          err_cnt = 0;
  int          n_pushed = 0;
  bit          calm = 1'b0;

  // stimulus-side view of the read
  logic [SYM_W-1:0] plan_read [READ_MAX];

  // predictor state
  logic [CFG_W-1:0] cur_len = kmrl_pkg::READ_LENGTH_RST;
  logic [CFG_W-1:0] cur_max = kmrl_pkg::MAX_MISMATCH_RST;
  logic [SYM_W-1:0] read_mem [READ_MAX];
  logic [SYM_W-1:0] win_mem [READ_MAX];
  int               win_fill = 0;
  longint           ref_pos = 0;
  longint           best_start = 0;
  int               best_cnt = 0;
  bit               hit_seen = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int eff_len(logic [CFG_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > READ_MAX) return READ_MAX;
    return int'(raw);
  endfunction

  task automatic note_error(input string msg);
    err_cnt++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic clear_scan_state();
    for (int i = 0; i < READ_MAX; i++) win_mem[i] = '0;
    win_fill = 0;
    ref_pos = 0;
    best_start = 0;
    best_cnt = 0;
    hit_seen = 1'b0;
  endtask

  task automatic shift_reference(input logic [SYM_W-1:0] sym);
    int len;
    int miss;
    len = eff_len(cur_len);
    miss = 0;
    for (int i = READ_MAX - 1; i > 0; i--) win_mem[i] = win_mem[i-1];
    win_mem[0] = sym;
    if (win_fill < READ_MAX) win_fill++;
    if (ref_pos < POS_LIMIT) begin
      ref_pos++;
      if (win_fill >= len) begin
        for (int j = 0; j < len; j++) if (read_mem[j] != win_mem[len-1-j]) miss++;
        if (miss <= cur_max && (!hit_seen || miss < best_cnt)) begin
          hit_seen = 1'b1;
          best_cnt = miss;
          best_start = ref_pos - len;
        end
      end
    end
  endtask

  task automatic apply_request(input req_item_t it);
    outcome_t o;
    case (it.kind)
      kmrl_pkg::REQ_LOAD: begin
        if (it.pos < READ_MAX) read_mem[it.pos] = it.sym;
      end
      kmrl_pkg::REQ_REF: shift_reference(it.sym);
      kmrl_pkg::REQ_FINISH: begin
        o.found = hit_seen;
        o.pos = hit_seen ? best_start[OUT_POS_W-1:0] : '0;
        o.cnt = hit_seen ? ((best_cnt > 255) ? 8'hFF : best_cnt[CNT_W-1:0]) : '0;
        outcome_q = {outcome_q, o};
        clear_scan_state();
      end
      default: ;
    endcase
  endtask

  initial begin
    for (int i = 0; i < READ_MAX; i++) begin
      read_mem[i] = '0;
      win_mem[i] = '0;
      plan_read[i] = '0;
    end
  end

  // driver
  req_item_t drv_item;
  int        drv_gap = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (drv_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        drv_gap <= drv_gap - 1;
      end else if (pending_q.size() != 0) begin
        drv_item = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, drv_item.pos, drv_item.sym};
        s_axis_tuser <= drv_item.kind;
        drv_gap <= pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result-side backpressure
  int stall_left = 0;

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // monitor
  req_item_t mon_item;
  outcome_t  got, want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == kmrl_pkg::REG_READ_LENGTH) cur_len = cfg_data_i;
        else cur_max = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        mon_item.kind = s_axis_tuser;
        mon_item.sym = s_axis_tdata[SYM_W-1:0];
        mon_item.pos = s_axis_tdata[SYM_W +: RPOS_W];
        apply_request(mon_item);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.found = m_axis_tuser;
        got.pos = m_axis_tdata[OUT_POS_W-1:0];
        got.cnt = m_axis_tdata[OUT_POS_W +: CNT_W];
        if (outcome_q.size() == 0) begin
          note_error("result transfer with no outcome pending");
        end else begin
          want = outcome_q.pop_front();
          if (got.found !== want.found)
            note_error($sformatf("found %0b, expected %0b", got.found, want.found));
          if (got.pos !== want.pos)
            note_error($sformatf("best_position %0d, expected %0d", got.pos, want.pos));
          if (got.cnt !== want.cnt)
            note_error($sformatf("best_mismatches %0d, expected %0d", got.cnt, want.cnt));
        end
      end
    end
  end

  task automatic push_item(input logic [REQ_W-1:0] kind, input logic [SYM_W-1:0] sym,
                           input logic [RPOS_W-1:0] pos);
    req_item_t it;
    it.kind = kind;
    it.sym = sym;
    it.pos = pos;
    if (kind == kmrl_pkg::REQ_LOAD) plan_read[pos] = sym;
    pending_q = {pending_q, it};
    n_pushed++;
  endtask

  task automatic push_ref(input logic [SYM_W-1:0] sym);
    push_item(kmrl_pkg::REQ_REF, sym, RPOS_W'($urandom_range(127)));
  endtask

  task automatic push_finish();
    push_item(kmrl_pkg::REQ_FINISH, SYM_W'($urandom_range(255)),
              RPOS_W'($urandom_range(127)));
  endtask

  // wait until every item is sent and every outcome seen, then let the block go idle
  task automatic wait_idle();
    while (pending_q.size() != 0 || s_axis_tvalid || outcome_q.size() != 0)
      @(posedge clk_i);
    repeat (READ_MAX + 8) @(posedge clk_i);
  endtask

  task automatic write_reg(input kmrl_pkg::reg_idx_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic program_regs(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] mm,
                              input bit both);
    wait_idle();
    if (both) write_reg(kmrl_pkg::REG_READ_LENGTH, len);
    write_reg(kmrl_pkg::REG_MAX_MISMATCH, mm);
  endtask

  task automatic push_noise(input int cnt, input int len);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(9) == 0) begin
        push_item(REQ_UNUSED, SYM_W'($urandom_range(255)), RPOS_W'($urandom_range(127)));
      end else if ($urandom_range(7) == 0) begin
        push_item(kmrl_pkg::REQ_LOAD, SYM_W'($urandom_range(255)),
                  RPOS_W'($urandom_range(127)));
      end else begin
        if ($urandom_range(1) == 0) push_ref(SYM_W'($urandom_range(255)));
        else push_ref(plan_read[$urandom_range(len - 1)]);
      end
    end
  endtask

  // one scan: noise with copies of the read carrying a few substitutions, then finish
  task automatic build_scan(input int len, input int mm);
    int reps;
    int nmut;
    logic [SYM_W-1:0] s;
    reps = (len > 16) ? $urandom_range(0, 1) : $urandom_range(0, 3);
    if ($urandom_range(5) != 0 && reps == 0) reps = 1;
    for (int r = 0; r < reps; r++) begin
      push_noise($urandom_range(0, (len > 16) ? 4 : 12), len);
      nmut = $urandom_range(0, (mm + 2 < len) ? mm + 2 : len);
      for (int j = 0; j < len; j++) begin
        s = plan_read[j];
        if ($urandom_range(len - 1) < nmut) s = s ^ SYM_W'($urandom_range(1, 255));
        push_ref(s);
      end
    end
    push_noise($urandom_range(0, 3), len);
    push_finish();
  endtask

  initial begin
    int r;
    int len;
    logic [CFG_W-1:0] len_raw;
    logic [CFG_W-1:0] mm_raw;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every read entry before any window is compared
    for (int i = 0; i < READ_MAX; i++)
      push_item(kmrl_pkg::REQ_LOAD, (i == 0) ? 8'h00 : (i == READ_MAX - 1) ? 8'hFF :
                SYM_W'($urandom_range(255)), RPOS_W'(i));

    // zero length acts as one, exact limit, tie keeps the earliest window
    program_regs(8'd0, 8'd0, 1'b1);
    push_ref(plan_read[0] ^ 8'h5A);
    push_ref(plan_read[0]);
    push_ref(plan_read[0]);
    push_finish();
    push_item(REQ_UNUSED, 8'hFF, 7'h7F);
    push_finish();

    // length above the store acts as the full store, every symbol missing
    program_regs(8'd255, 8'd128, 1'b1);
    for (int j = 0; j < READ_MAX; j++) push_ref(~plan_read[j]);
    push_finish();

    // no hit, then a load during the scan changes the next comparison
    program_regs(8'd4, 8'd1, 1'b1);
    push_ref(8'h00);
    push_ref(8'hFF);
    push_ref(plan_read[0] ^ 8'h01);
    push_ref(plan_read[1]);
    push_ref(plan_read[2] ^ 8'h80);
    push_ref(plan_read[3]);
    push_finish();
    push_ref(plan_read[0]);
    push_item(kmrl_pkg::REQ_LOAD, plan_read[3] ^ 8'h3C, 7'd3);
    push_ref(plan_read[1]);
    push_ref(plan_read[2]);
    push_ref(plan_read[3]);
    push_finish();

    while (n_pushed < 1200) begin
      r = $urandom_range(99);
      if (r < 65) len_raw = CFG_W'($urandom_range(1, 12));
      else if (r < 80) len_raw = CFG_W'($urandom_range(13, 127));
      else if (r < 88) len_raw = 8'd128;
      else if (r < 93) len_raw = 8'd0;
      else if (r < 97) len_raw = CFG_W'($urandom_range(129, 255));
      else len_raw = 8'd1;
      len = eff_len(len_raw);
      r = $urandom_range(99);
      if (r < 70) mm_raw = CFG_W'($urandom_range(0, len / 3));
      else if (r < 80) mm_raw = 8'd0;
      else if (r < 90) mm_raw = 8'd255;
      else mm_raw = 8'd128;
      wait_idle();
      calm = ($urandom_range(4) == 0);
      if ($urandom_range(5) == 0) len_raw = cur_len;
      len = eff_len(len_raw);
      program_regs(len_raw, mm_raw, len_raw != cur_len || $urandom_range(1) == 0);
      build_scan(len, int'(mm_raw));
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("tb_k_mismatch_read_locator: done, clean");
    end else begin
      $display("tb_k_mismatch_read_locator: done, errors");
    end
    $finish;
  end

  initial begin
    #(64'd25_000_000);
    $display("tb_k_mismatch_read_locator: done, errors");
    $finish;
  end

endmodule
